[rtl/core/dq_pkg.sv]
// Shared types and constants for the double-ended queue unit.
// Holds the request and response item structs and the operation codes.
// No dependencies.
`default_nettype none

package dq_pkg;

   localparam int VALUE_FIELD_BITS = 32;
   localparam int COUNT_FIELD_BITS = 5;

   typedef enum logic [1:0] {
      MODE_PUSH_BACK  = 2'd0,
      MODE_PUSH_FRONT = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_BACK,
      CELL_PUSH_FRONT,
      CELL_POP_FRONT,
      CELL_POP_BACK
   } cell_op_type;

   typedef struct packed {
      mode_type                            mode;
      logic signed [VALUE_FIELD_BITS-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_FIELD_BITS-1:0]  pop_value;
      logic [COUNT_FIELD_BITS-1:0]         entry_count;
      logic                                is_empty;
      status_type                          status;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/dq_cell.sv]
// One storage cell of the queue row: a word and its occupied flag.
// Shifts with its neighbors on front operations; depends on dq_pkg.
`default_nettype none

module dq_cell #(
   parameter int STORE_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  dq_pkg::cell_op_type          op,
   input  wire logic [STORE_BITS-1:0]   push_data,
   input  wire logic [STORE_BITS-1:0]   left_data,
   input  wire logic                    left_occ,
   input  wire logic [STORE_BITS-1:0]   right_data,
   input  wire logic                    right_occ,
   output logic [STORE_BITS-1:0]        data,
   output logic                         occ,
   output logic [STORE_BITS-1:0]        back_data
);
   import dq_pkg::*;

   logic [STORE_BITS-1:0] data_ff;
   logic [STORE_BITS-1:0] data_in;
   logic                  occ_ff;
   logic                  occ_in;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      case (op)
         CELL_PUSH_BACK: begin
            if (!occ_ff && left_occ) begin
               data_in = push_data;
               occ_in  = 1'b1;
            end
         end
         CELL_PUSH_FRONT: begin
            data_in = left_data;
            occ_in  = left_occ;
         end
         CELL_POP_FRONT: begin
            data_in = right_data;
            occ_in  = right_occ;
         end
         CELL_POP_BACK: begin
            if (occ_ff && !right_occ) begin
               occ_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign occ       = occ_ff;
   assign back_data = (occ_ff && !right_occ) ? data_ff : '0;

endmodule

`default_nettype wire

[rtl/core/double_ended_queue_unit.sv]
// Top level of the double-ended queue unit: a row of dq_cell storage cells,
// the request decode and the registered response stage. Depends on dq_pkg.
//
// The queue is kept as a row of DEPTH cells with the front entry always in
// the first cell; front pushes and pops shift the whole row by one place,
// back pushes fill the first free cell, and back pops clear the last
// occupied one. Every request gives one response item, so one item is taken
// per clock while the response register is free or being drained. The
// longest path is the select of the back entry, an OR across all DEPTH
// cells. No clearing pass is needed after reset.
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  dq_pkg::req_type       req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dq_pkg::rsp_type       rsp_payload
);
   import dq_pkg::*;

   localparam int STORE_BITS = (WORD_BITS < VALUE_FIELD_BITS) ? WORD_BITS : VALUE_FIELD_BITS;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   logic [STORE_BITS-1:0] cell_data [DEPTH];
   logic [STORE_BITS-1:0] cell_back [DEPTH];
   logic [DEPTH-1:0]      cell_occ;
   logic [STORE_BITS-1:0] push_data;
   logic [STORE_BITS-1:0] back_value;
   logic [STORE_BITS-1:0] pop_store;
   logic [STORE_BITS+VALUE_FIELD_BITS-1:0] pop_wide;
   logic [CNT_BITS+COUNT_FIELD_BITS-1:0]   count_wide;

   cell_op_type           op_sel;
   cell_op_type           cell_op;
   status_type            status_sel;
   logic                  req_fire;
   logic                  full;
   logic                  empty;

   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_payload_ff;
   rsp_type               rsp_payload_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign push_data = req_payload.push_value[STORE_BITS-1:0];
   assign full      = cell_occ[DEPTH-1];
   assign empty     = !cell_occ[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [STORE_BITS-1:0] left_data;
      logic                  left_occ;
      logic [STORE_BITS-1:0] right_data;
      logic                  right_occ;

      if (i == 0) begin : g_first
         assign left_data = push_data;
         assign left_occ  = 1'b1;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
         assign left_occ  = cell_occ[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
         assign right_occ  = 1'b0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      dq_cell #(
         .STORE_BITS (STORE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_op),
         .push_data  (push_data),
         .left_data  (left_data),
         .left_occ   (left_occ),
         .right_data (right_data),
         .right_occ  (right_occ),
         .data       (cell_data[i]),
         .occ        (cell_occ[i]),
         .back_data  (cell_back[i])
      );
   end

   // Only the last occupied cell drives a nonzero back value.
   always_comb begin
      back_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_value = back_value | cell_back[i];
      end
   end

   always_comb begin
      op_sel     = CELL_HOLD;
      status_sel = STATUS_OK;
      count_in   = count_ff;
      pop_store  = '0;
      case (req_payload.mode)
         MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
            if (full) begin
               status_sel = STATUS_OVERFLOW;
            end else begin
               op_sel   = (req_payload.mode == MODE_PUSH_BACK) ? CELL_PUSH_BACK
                                                                : CELL_PUSH_FRONT;
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status_sel = STATUS_UNDERFLOW;
            end else begin
               op_sel    = CELL_POP_FRONT;
               pop_store = cell_data[0];
               count_in  = count_ff - CNT_BITS'(1);
            end
         end
         MODE_POP_BACK: begin
            if (empty) begin
               status_sel = STATUS_UNDERFLOW;
            end else begin
               op_sel    = CELL_POP_BACK;
               pop_store = back_value;
               count_in  = count_ff - CNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign cell_op    = req_fire ? op_sel : CELL_HOLD;
   assign pop_wide   = {{VALUE_FIELD_BITS{1'b0}}, pop_store};
   assign count_wide = {{COUNT_FIELD_BITS{1'b0}}, count_in};

   always_comb begin
      rsp_payload_in.pop_value   = pop_wide[VALUE_FIELD_BITS-1:0];
      rsp_payload_in.entry_count = count_wide[COUNT_FIELD_BITS-1:0];
      rsp_payload_in.is_empty    = (count_in == '0);
      rsp_payload_in.status      = status_sel;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire
